### rtl/doel_pkg.sv
// shared types and constants of the date ordered event list
package doel_pkg;

   // field widths
   localparam int CMD_W  = 2;
   localparam int DATE_W = 32;
   localparam int TAG_W  = 16;
   localparam int KIND_W = 3;

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LIST   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // result kinds on the response channel
   localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ENTRY    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd4;

   // command queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // decoded operation
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LIST,
      OP_CLEAR
   } op_type;

   // one queued command
   typedef struct packed {
      op_type              op;
      logic [DATE_W-1:0]   date;
      logic [TAG_W-1:0]    tag;
   } cmd_item_type;

endpackage

### rtl/date_ordered_event_list.sv
// Date ordered event list: a bounded table of events kept in ascending date order.
// The request channel (req_valid/req_ready) carries a command with a date and a
// tag: insert, read out all entries, or clear. The undefined command code is
// accepted and dropped without a response.
// The response channel (rsp_valid/rsp_ready) returns kind, date, tag and last.
// An insert answers inserted or rejected full; ties go after equal dates.
// A read-out returns one transaction per stored entry in order, last set on the
// final one, or a single empty marker. A clear answers cleared.
// With an idle engine, an accepted request is stored in the command queue, taken
// by the list engine and answered from the response register; a read-out first
// enters its read-out state, then registers its entries. The engine takes a new
// insert or clear whenever the response register is free; a read-out emits one
// stored entry per cycle while the receiver is ready, by rotating the occupied
// cells through cell zero, and takes no new command until its last entry. A
// two-entry command queue lets requests be accepted while the engine works or the
// response register waits. Reset empties the list and the queue and drops any
// pending response; no clearing pass is needed. When the receiver stalls, the
// held response blocks the engine, the queue fills, and req_ready falls.
module date_ordered_event_list #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [doel_pkg::CMD_W-1:0]     req_cmd,
   input  logic [doel_pkg::DATE_W-1:0]    req_event_date,
   input  logic [doel_pkg::TAG_W-1:0]     req_event_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [doel_pkg::KIND_W-1:0]    rsp_kind,
   output logic [doel_pkg::DATE_W-1:0]    rsp_out_date,
   output logic [doel_pkg::TAG_W-1:0]     rsp_out_tag,
   output logic                           rsp_last
);
   import doel_pkg::*;

   logic          push_valid;
   logic          push_ready;
   cmd_item_type  push_item;
   logic          pop_valid;
   logic          pop_ready;
   cmd_item_type  pop_item;

   // request decode
   doel_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_event_date (req_event_date),
      .req_event_tag  (req_event_tag),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   // command queue
   doel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // list engine
   doel_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_item     (pop_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_date (rsp_out_date),
      .rsp_out_tag  (rsp_out_tag),
      .rsp_last     (rsp_last)
   );

endmodule

### rtl/doel_front.sv
// front end: accepts request transactions and decodes them into queue items
module doel_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [doel_pkg::CMD_W-1:0]    req_cmd,
   input  logic [doel_pkg::DATE_W-1:0]   req_event_date,
   input  logic [doel_pkg::TAG_W-1:0]    req_event_tag,
   output logic                          push_valid,
   input  logic                          push_ready,
   output doel_pkg::cmd_item_type        push_item
);
   import doel_pkg::*;

   logic keep;

   // decode the command, the undefined code is dropped on acceptance
   always_comb begin
      push_item.op   = OP_INSERT;
      push_item.date = req_event_date;
      push_item.tag  = req_event_tag;
      keep           = 1'b1;
      case (req_cmd)
         CMD_INSERT: push_item.op = OP_INSERT;
         CMD_LIST:   push_item.op = OP_LIST;
         CMD_CLEAR:  push_item.op = OP_CLEAR;
         default:    keep = 1'b0;
      endcase
   end

   // accept whenever the queue has room
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

### rtl/doel_queue.sv
// small command queue decoupling the front end from the list engine
module doel_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  doel_pkg::cmd_item_type  push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output doel_pkg::cmd_item_type  pop_item
);
   import doel_pkg::*;

   cmd_item_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  fill_ff, fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (fill_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers wrap naturally since the depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/doel_back.sv
// list engine: sorted table of cells, insert by parallel compare and shift,
// read-out by rotating the occupied cells through cell zero
module doel_back #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  doel_pkg::cmd_item_type         pop_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [doel_pkg::KIND_W-1:0]    rsp_kind,
   output logic [doel_pkg::DATE_W-1:0]    rsp_out_date,
   output logic [doel_pkg::TAG_W-1:0]     rsp_out_tag,
   output logic                           rsp_last
);
   import doel_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                 state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_m1;
   logic [DATE_W-1:0]    date_ff [DEPTH];
   logic [DATE_W-1:0]    date_in [DEPTH];
   logic [TAG_W-1:0]     tag_ff [DEPTH];
   logic [TAG_W-1:0]     tag_in [DEPTH];
   logic [DATE_W-1:0]    date_prev [DEPTH];
   logic [TAG_W-1:0]     tag_prev [DEPTH];
   logic [DATE_W-1:0]    date_next [DEPTH];
   logic [TAG_W-1:0]     tag_next [DEPTH];
   logic [DEPTH-1:0]     later;
   logic [DEPTH-1:0]     later_prev;
   logic                 out_free;
   logic                 take;
   logic                 list_last;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [DATE_W-1:0]    out_date_ff, out_date_in;
   logic [TAG_W-1:0]     out_tag_ff, out_tag_in;
   logic                 last_ff, last_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = pop_valid && pop_ready;
   assign count_m1  = count_ff - CW'(1);
   assign list_last = (idx_ff == count_m1);

   // neighbor views of the cells, each cell sees fixed positions only
   always_comb begin
      date_prev[0]        = date_ff[0];
      tag_prev[0]         = tag_ff[0];
      date_next[DEPTH-1]  = date_ff[DEPTH-1];
      tag_next[DEPTH-1]   = tag_ff[DEPTH-1];
      for (int i = 1; i < DEPTH; i++) begin
         date_prev[i]   = date_ff[i-1];
         tag_prev[i]    = tag_ff[i-1];
         date_next[i-1] = date_ff[i];
         tag_next[i-1]  = tag_ff[i];
      end
   end

   // occupied cells holding a strictly later date than the new event
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         later[i] = (CW'(i) < count_ff) && (date_ff[i] > pop_item.date);
      end
      later_prev = {later[DEPTH-2:0], 1'b0};
   end

   // next state of table, sequencer and response register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      for (int i = 0; i < DEPTH; i++) begin
         date_in[i] = date_ff[i];
         tag_in[i]  = tag_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      out_date_in  = out_date_ff;
      out_tag_in   = out_tag_ff;
      last_in      = last_ff;

      if (take) begin
         rsp_valid_in = 1'b1;
         out_date_in  = '0;
         out_tag_in   = '0;
         last_in      = 1'b1;
         kind_in      = KIND_CLEARED;
         case (pop_item.op)
            OP_INSERT: begin
               if (count_ff == CW'(DEPTH)) begin
                  kind_in = KIND_FULL;
               end else begin
                  kind_in  = KIND_INSERTED;
                  count_in = count_ff + CW'(1);
                  // later cells move up one, the first later cell (or the first free cell) takes the event
                  for (int i = 0; i < DEPTH; i++) begin
                     if (later_prev[i]) begin
                        date_in[i] = date_prev[i];
                        tag_in[i]  = tag_prev[i];
                     end else if (later[i] || (CW'(i) == count_ff)) begin
                        date_in[i] = pop_item.date;
                        tag_in[i]  = pop_item.tag;
                     end
                  end
               end
            end
            OP_LIST: begin
               if (count_ff == '0) begin
                  kind_in = KIND_EMPTY;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  kind_in      = kind_ff;
                  out_date_in  = out_date_ff;
                  out_tag_in   = out_tag_ff;
                  last_in      = last_ff;
                  state_in     = ST_LIST;
                  idx_in       = '0;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
               kind_in      = kind_ff;
               last_in      = last_ff;
            end
         endcase
      end else if ((state_ff == ST_LIST) && out_free) begin
         // emit cell zero and rotate the occupied cells down by one
         rsp_valid_in = 1'b1;
         kind_in      = KIND_ENTRY;
         out_date_in  = date_ff[0];
         out_tag_in   = tag_ff[0];
         last_in      = list_last;
         idx_in       = idx_ff + CW'(1);
         for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) < count_m1) begin
               date_in[i] = date_next[i];
               tag_in[i]  = tag_next[i];
            end else if (CW'(i) == count_m1) begin
               date_in[i] = date_ff[0];
               tag_in[i]  = tag_ff[0];
            end
         end
         if (list_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // table cells and response payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      out_date_ff <= out_date_in;
      out_tag_ff  <= out_tag_in;
      last_ff     <= last_in;
      for (int i = 0; i < DEPTH; i++) begin
         date_ff[i] <= date_in[i];
         tag_ff[i]  <= tag_in[i];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_date = out_date_ff;
   assign rsp_out_tag  = out_tag_ff;
   assign rsp_last     = last_ff;

endmodule
